@@ rtl/core/csee_pkg.sv @@
// C string escape encoder: shared payload types, character constants and
// the byte classification function. Used by every module of the block.
`timescale 1ns / 1ps

package csee_pkg;

    // Character constants
    localparam logic [7:0] CH_BACKSLASH = 8'h5c;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_X         = 8'h78;
    localparam logic [7:0] PRINT_LO     = 8'h20;
    localparam logic [7:0] PRINT_HI     = 8'h7e;
    localparam logic [7:0] CTL_LO       = 8'h07;
    localparam logic [7:0] CTL_HI       = 8'h0d;

    localparam logic [0:15][7:0] HEX_DIGITS  = "0123456789abcdef";
    localparam logic [0:6][7:0]  CTL_LETTERS = "abtnvfr";

    // Escape lengths, stored as length minus one
    localparam logic [1:0] LEN1 = 2'd0;
    localparam logic [1:0] LEN2 = 2'd1;
    localparam logic [1:0] LEN4 = 2'd3;

    // Configuration register map
    localparam logic REG_OUT_CAPACITY = 1'b0;
    localparam logic [15:0] CAPACITY_RESET = 16'hffff;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_char;
        logic        run_end;
        logic [15:0] written_count;
    } t_out_item;

    // One classified byte: its escape characters, length and the count
    // before its first character
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      len_m1;
        logic [15:0]     base;
    } t_job;

    function automatic t_job escape_byte(input logic [7:0] b);
        t_job       j;
        logic [2:0] ci;
        j      = '0;
        ci     = 3'(b - CTL_LO);
        if (b >= PRINT_LO && b <= PRINT_HI) begin
            if (b == CH_QUOTE || b == CH_BACKSLASH) begin
                j.chars[0] = CH_BACKSLASH;
                j.chars[1] = b;
                j.len_m1   = LEN2;
            end else begin
                j.chars[0] = b;
                j.len_m1   = LEN1;
            end
        end else if (b >= CTL_LO && b <= CTL_HI) begin
            j.chars[0] = CH_BACKSLASH;
            j.chars[1] = CTL_LETTERS[ci];
            j.len_m1   = LEN2;
        end else if (b == 8'h00) begin
            j.chars[0] = CH_BACKSLASH;
            j.chars[1] = CH_ZERO;
            j.len_m1   = LEN2;
        end else begin
            j.chars[0] = CH_BACKSLASH;
            j.chars[1] = CH_X;
            j.chars[2] = HEX_DIGITS[b[7:4]];
            j.chars[3] = HEX_DIGITS[b[3:0]];
            j.len_m1   = LEN4;
        end
        return j;
    endfunction

endpackage

@@ rtl/core/csee_front.sv @@
// Front part: accepts input bytes, classifies them, tracks the per-string
// budget and count, and pushes one job per emitting byte. Uses csee_pkg.
`timescale 1ns / 1ps

module csee_front #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  csee_pkg::t_in_item i_item,
    input  logic [15:0]       i_capacity,
    input  logic              i_q_full,
    output logic              o_q_push,
    output csee_pkg::t_job    o_job
);

    logic                   r_fresh, n_fresh;
    logic                   r_halted, n_halted;
    logic [15:0]            r_budget, n_budget;
    logic [COUNT_WIDTH-1:0] r_count, n_count;

    logic                   take;
    logic                   halted_eff;
    logic [15:0]            budget_eff;
    logic [COUNT_WIDTH-1:0] count_eff;
    logic [2:0]             len;
    logic                   fits;
    csee_pkg::t_job         esc;

    assign take = i_push && !i_q_full;

    // Start of a string: reload budget, clear stop flag and count
    assign halted_eff = r_fresh ? 1'b0 : r_halted;
    assign budget_eff = r_fresh ? i_capacity : r_budget;
    assign count_eff  = r_fresh ? '0 : r_count;

    assign esc  = csee_pkg::escape_byte(i_item.in_byte);
    assign len  = {1'b0, esc.len_m1} + 3'd1;
    assign fits = {13'd0, len} <= budget_eff;

    // Build the job for the queue
    always_comb begin
        o_job      = esc;
        o_job.base = 16'(count_eff);
        o_q_push   = take && !halted_eff && fits;
    end

    // Next string state
    always_comb begin
        n_fresh  = r_fresh;
        n_halted = r_halted;
        n_budget = r_budget;
        n_count  = r_count;
        if (take) begin
            n_fresh  = i_item.last_byte;
            n_halted = halted_eff;
            n_budget = budget_eff;
            n_count  = count_eff;
            if (!halted_eff) begin
                if (fits) begin
                    n_budget = budget_eff - {13'd0, len};
                    n_count  = count_eff + COUNT_WIDTH'(len);
                end else begin
                    n_halted = 1'b1;
                end
            end
        end
    end

    // Hold string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fresh  <= 1'b1;
            r_halted <= 1'b0;
            r_budget <= csee_pkg::CAPACITY_RESET;
            r_count  <= '0;
        end else begin
            r_fresh  <= n_fresh;
            r_halted <= n_halted;
            r_budget <= n_budget;
            r_count  <= n_count;
        end
    end

endmodule

@@ rtl/core/csee_jobq.sv @@
// Two-entry job queue between the front and back parts.
// Uses the job type from csee_pkg.
`timescale 1ns / 1ps

module csee_jobq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  csee_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output csee_pkg::t_job o_head
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    csee_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]  r_wptr, r_rptr;
    logic [AW:0]    r_cnt, n_cnt;
    logic           do_push, do_pop;

    assign o_full  = r_cnt == (AW+1)'(DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_cnt = r_cnt;
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

@@ rtl/core/csee_back.sv @@
// Back part: walks the head job's characters into the result register,
// one per cycle while that is free or popped. Uses csee_pkg.
`timescale 1ns / 1ps

module csee_back #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  csee_pkg::t_job     i_head,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output csee_pkg::t_out_item o_item
);

    logic                    r_valid;
    csee_pkg::t_out_item     r_item;
    logic [1:0]              r_idx;
    logic                    load;
    logic                    last_char;
    logic [COUNT_WIDTH-1:0]  wc;

    assign load      = !i_q_empty && (!r_valid || i_pop);
    assign last_char = r_idx == i_head.len_m1;
    assign o_q_pop   = load && last_char;
    assign wc        = COUNT_WIDTH'(i_head.base) + COUNT_WIDTH'({1'b0, r_idx} + 3'd1);

    assign o_empty = !r_valid;
    assign o_item  = r_item;

    // Hold the result until taken, refill as soon as it goes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= last_char ? 2'd0 : r_idx + 2'd1;
            end else if (i_pop) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item.out_char      <= i_head.chars[r_idx];
            r_item.run_end       <= last_char;
            r_item.written_count <= 16'(wc);
        end
    end

endmodule

@@ rtl/core/c_string_escape_encoder_core.sv @@
// Top level of the C string escape encoder: configuration register,
// front part, job queue and back part. Uses csee_pkg and three csee_ modules.
`timescale 1ns / 1ps

// Usage
//   Input queue: drive i_item and raise push; the byte transfers at an edge
//   where push is high and full is low. last_byte marks the end of a string.
//   Result queue: while empty is low, o_item holds the oldest character;
//   raise pop to transfer it. Each input byte gives 1, 2 or 4 characters,
//   or none once the string has run out of budget.
//   Path: a byte's job is written into the job queue, and its first
//   character then goes from there into the back part's result register.
//   Throughput: one character per cycle while each result is popped as it
//   appears, set by the back part's result register; a byte with n
//   characters loads it n times, so hex escapes take four loads per byte.
//   Stalls: a two-entry job queue sits between front and back; full rises
//   when it holds two jobs and falls the cycle after the back part takes
//   the last character of the oldest job.
//   Configuration: out_capacity at byte address 0 over the APB port, read
//   and write; it applies from the next string onwards.
//   Reset: both queues empty, out_capacity returns to 65535 and the next
//   byte starts a new string. No clearing pass is needed.

module c_string_escape_encoder_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  csee_pkg::t_in_item  i_item,
    output logic                empty,
    input  logic                pop,
    output csee_pkg::t_out_item o_item,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    logic [15:0]    r_capacity;
    logic           q_push, q_pop, q_full, q_empty;
    csee_pkg::t_job f_job, q_head;

    // Configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == csee_pkg::REG_OUT_CAPACITY) ? {16'd0, r_capacity} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= csee_pkg::CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == csee_pkg::REG_OUT_CAPACITY) begin
            r_capacity <= pwdata[15:0];
        end
    end

    assign full = q_full;

    csee_front #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_item    (i_item),
        .i_capacity(r_capacity),
        .i_q_full  (q_full),
        .o_q_push  (q_push),
        .o_job     (f_job)
    );

    csee_jobq u_jobq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_job  (f_job),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_head (q_head)
    );

    csee_back #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_empty(q_empty),
        .i_head   (q_head),
        .o_q_pop  (q_pop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_item   (o_item)
    );

endmodule

@@ rtl/core/csee_checker.sv @@
// Port-level checks for the C string escape encoder, bound to the top
// level. Uses the payload types from csee_pkg.
`timescale 1ns / 1ps

module csee_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input csee_pkg::t_out_item o_item,
    input logic                pready
);

    // Reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // Reset leaves room for input
    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input queue full after reset");

    // A waiting result that is not taken stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_item)))
        else $error("waiting result changed or vanished");

    // The rest of an escape follows without a gap
    a_escape_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_item.run_end) |=> !empty)
        else $error("gap inside an escape sequence");

    // Register port never waits
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind c_string_escape_encoder_core csee_checker u_csee_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .full   (full),
    .empty  (empty),
    .pop    (pop),
    .o_item (o_item),
    .pready (pready)
);
